[rtl/ple_pkg.sv]
package ple_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 8;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int IN_W        = POS_W + DATA_WIDTH;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = STATUS_W + DATA_WIDTH + IDX_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DEL_POS  = 2'd1,
        OP_DEL_VAL  = 2'd2,
        OP_TRAVERSE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CM_HOLD    = 3'd0,
        CM_INSERT  = 3'd1,
        CM_REMOVE  = 3'd2,
        CM_ROTATE  = 3'd3,
        CM_COMPARE = 3'd4
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t             mode;
        logic [IDX_W-1:0]       pos;
        logic [CNT_W-1:0]       cnt;
        logic [DATA_WIDTH-1:0]  data;
    } cell_cmd_t;

    typedef struct packed {
        logic                   valid;
        status_t                status;
        logic [DATA_WIDTH-1:0]  element;
        logic [IDX_W-1:0]       index;
        logic [CNT_W-1:0]       cnt;
        logic                   last;
    } result_t;

endpackage

[rtl/positional_list_engine.sv]
// insert and delete at position: result registered in the cycle after the request is taken
// delete by value: a registered per-cell compare, then the shift once the output can advance
// traverse: entries in order from the head of the cell chain, one entry per cycle while the
// output can advance; the chain rotates once per emitted entry
// a new request is taken once the previous one has finished and the output can advance
// reset clears the entry count and control state; cell contents stay undefined until written
module positional_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ple_pkg::IN_TDATA_W-1:0]      s_tdata,  // position, data
    input  logic [ple_pkg::OP_W-1:0]            s_tuser,  // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ple_pkg::OUT_TDATA_W-1:0]     m_tdata,  // status, element, index, count
    output logic                                m_tlast
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] entries [DEPTH];
    logic [DEPTH-1:0]      match_bits;
    cell_cmd_t             cmd;
    result_t               res;
    logic [CNT_W-1:0]      cnt;

    ple_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser),
        .req_pos    (s_tdata[POS_W-1:0]),
        .req_data   (s_tdata[POS_W +: DATA_WIDTH]),
        .res_ready  (m_tready),
        .res        (res),
        .head_entry (entries[0]),
        .match_bits (match_bits),
        .cmd        (cmd),
        .cnt        (cnt)
    );

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_entry;
        logic [DATA_WIDTH-1:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = entries[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_mid_r
            assign right_entry = entries[g+1];
        end

        ple_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .cell_idx    (IDX_W'(g)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .wrap_entry  (entries[0]),
            .entry       (entries[g]),
            .match       (match_bits[g])
        );
    end

    assign m_tvalid = res.valid;
    assign m_tlast  = res.last;
    assign m_tdata  = OUT_TDATA_W'({res.cnt, res.index, res.element, res.status});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_INSERT) && (cnt == CNT_W'(DEPTH))
        |=> m_tvalid && (res.status == ST_FULL) && (cnt == CNT_W'(DEPTH)))
        else $error("insert into full list not rejected");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_INSERT) && (cnt < CNT_W'(DEPTH))
        |=> (cnt == $past(cnt) + 1'b1) && m_tvalid && (res.status == ST_OK))
        else $error("insert did not add one entry");
`endif

endmodule

[rtl/ple_cell.sv]
module ple_cell (
    input  logic                            clk,
    input  ple_pkg::cell_cmd_t              cmd,
    input  logic [ple_pkg::IDX_W-1:0]       cell_idx,
    input  logic [ple_pkg::DATA_WIDTH-1:0]  left_entry,
    input  logic [ple_pkg::DATA_WIDTH-1:0]  right_entry,
    input  logic [ple_pkg::DATA_WIDTH-1:0]  wrap_entry,
    output logic [ple_pkg::DATA_WIDTH-1:0]  entry,
    output logic                            match
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  match_reg;
    logic                  match_next;
    logic [CNT_W-1:0]      idx_ext;
    logic [CNT_W-1:0]      pos_ext;

    assign idx_ext = CNT_W'(cell_idx);
    assign pos_ext = CNT_W'(cmd.pos);

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (cmd.mode)
            CM_HOLD:
            begin
            end
            CM_INSERT:
            begin
                if (idx_ext > pos_ext)
                begin
                    entry_next = left_entry;
                end
                else if (idx_ext == pos_ext)
                begin
                    entry_next = cmd.data;
                end
            end
            CM_REMOVE:
            begin
                if (idx_ext >= pos_ext)
                begin
                    entry_next = right_entry;
                end
            end
            CM_ROTATE:
            begin
                // cell 0 wraps around to the tail of the list
                if (idx_ext + 1'b1 < cmd.cnt)
                begin
                    entry_next = right_entry;
                end
                else if (idx_ext + 1'b1 == cmd.cnt)
                begin
                    entry_next = wrap_entry;
                end
            end
            CM_COMPARE:
            begin
                match_next = (entry_reg == cmd.data) && (idx_ext < cmd.cnt);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[rtl/ple_ctrl.sv]
module ple_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [ple_pkg::OP_W-1:0]        req_op,
    input  logic [ple_pkg::POS_W-1:0]       req_pos,
    input  logic [ple_pkg::DATA_WIDTH-1:0]  req_data,
    input  logic                            res_ready,
    output ple_pkg::result_t                res,
    input  logic [ple_pkg::DATA_WIDTH-1:0]  head_entry,
    input  logic [ple_pkg::DEPTH-1:0]       match_bits,
    output ple_pkg::cell_cmd_t              cmd,
    output logic [ple_pkg::CNT_W-1:0]       cnt
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_TRAV  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  trav_reg;
    logic [IDX_W-1:0]  trav_next;
    result_t           res_reg;
    result_t           res_next;
    logic              out_free;
    logic              accept;
    logic              found;
    logic [IDX_W-1:0]  hit;
    logic              trav_last;
    op_t               op;

    assign op        = op_t'(req_op);
    assign out_free  = !res_reg.valid || res_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign trav_last = (CNT_W'(trav_reg) + 1'b1) == cnt_reg;

    // lowest matching cell wins
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_bits[i])
            begin
                found = 1'b1;
                hit   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        trav_next  = trav_reg;
        res_next   = res_reg;
        if (res_ready)
        begin
            res_next.valid = 1'b0;
        end
        cmd.mode = CM_HOLD;
        cmd.pos  = '0;
        cmd.cnt  = cnt_reg;
        cmd.data = req_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{valid: 1'b1, status: ST_OK, element: '0, index: '0,
                                 cnt: cnt_reg, last: 1'b1};
                    unique case (op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.mode = CM_INSERT;
                                if (req_pos >= POS_W'(cnt_reg))
                                begin
                                    cmd.pos = cnt_reg[IDX_W-1:0];
                                end
                                else
                                begin
                                    cmd.pos = req_pos[IDX_W-1:0];
                                end
                                cnt_next     = cnt_reg + 1'b1;
                                res_next.cnt = cnt_next;
                            end
                        end
                        OP_DEL_POS:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (req_pos >= POS_W'(cnt_reg))
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.mode     = CM_REMOVE;
                                cmd.pos      = req_pos[IDX_W-1:0];
                                cnt_next     = cnt_reg - 1'b1;
                                res_next.cnt = cnt_next;
                            end
                        end
                        OP_DEL_VAL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.mode       = CM_COMPARE;
                                res_next.valid = 1'b0;
                                state_next     = S_MATCH;
                            end
                        end
                        OP_TRAVERSE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                res_next.valid = 1'b0;
                                trav_next      = '0;
                                state_next     = S_TRAV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MATCH:
            begin
                if (out_free)
                begin
                    res_next = '{valid: 1'b1, status: ST_NOTFOUND, element: '0, index: '0,
                                 cnt: cnt_reg, last: 1'b1};
                    if (found)
                    begin
                        cmd.mode        = CM_REMOVE;
                        cmd.pos         = hit;
                        cnt_next        = cnt_reg - 1'b1;
                        res_next.status = ST_OK;
                        res_next.cnt    = cnt_next;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TRAV:
            begin
                if (out_free)
                begin
                    // emit the head and rotate the chain by one cell
                    cmd.mode = CM_ROTATE;
                    res_next = '{valid: 1'b1, status: ST_OK, element: head_entry,
                                 index: trav_reg, cnt: cnt_reg, last: trav_last};
                    trav_next = trav_reg + 1'b1;
                    if (trav_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            trav_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            trav_reg  <= trav_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;
    assign cnt = cnt_reg;

endmodule

[bench/positional_list_engine_checker.sv]
`timescale 1ns / 100ps

module positional_list_engine_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ple_pkg::IN_TDATA_W-1:0]  s_tdata,   // position, data
    input  logic [ple_pkg::OP_W-1:0]        s_tuser,   // operation
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ple_pkg::OUT_TDATA_W-1:0] m_tdata,   // status, element, index, count
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              outstanding
);
    import ple_pkg::*;

    localparam int ELEM_LO  = STATUS_W;
    localparam int INDEX_LO = ELEM_LO + DATA_WIDTH;
    localparam int COUNT_LO = INDEX_LO + IDX_W;

    typedef struct packed {
        status_t                status;
        logic [DATA_WIDTH-1:0]  element;
        logic [IDX_W-1:0]       index;
        logic [CNT_W-1:0]       cnt;
        logic                   is_last;
    } list_result_t;

    logic [DATA_WIDTH-1:0]  list_words [DEPTH];
    int                     list_len;
    list_result_t           pending_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        list_len    = 0;
    end

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic push_result(input status_t st, input logic [DATA_WIDTH-1:0] elem,
                               input int idx, input logic is_last);
        list_result_t r;
        r.status  = st;
        r.element = elem;
        r.index   = IDX_W'(idx);
        r.cnt     = CNT_W'(list_len);
        r.is_last = is_last;
        pending_results.push_back(r);
    endtask

    task automatic remove_word(input int at);
        for (int i = at; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
    endtask

    // updates the shadow list and queues every result the request causes
    task automatic predict_list_op(input op_t op, input int pos,
                                   input logic [DATA_WIDTH-1:0] word);
        int  at;
        bit  found;
        at    = 0;
        found = 0;
        case (op)
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    push_result(ST_FULL, '0, 0, 1'b1);
                end
                else
                begin
                    at = (pos > list_len) ? list_len : pos;
                    for (int i = list_len; i > at; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[at] = word;
                    list_len++;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            OP_DEL_POS:
            begin
                if (list_len == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                else if (pos >= list_len)
                    push_result(ST_RANGE, '0, 0, 1'b1);
                else
                begin
                    remove_word(pos);
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            OP_DEL_VAL:
            begin
                if (list_len == 0)
                begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < list_len && !found; i++)
                    begin
                        if (list_words[i] == word)
                        begin
                            found = 1;
                            at    = i;
                        end
                    end
                    if (found)
                    begin
                        remove_word(at);
                        push_result(ST_OK, '0, 0, 1'b1);
                    end
                    else
                    begin
                        push_result(ST_NOTFOUND, '0, 0, 1'b1);
                    end
                end
            end
            default:
            begin
                if (list_len == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        push_result(ST_OK, list_words[i], i, i + 1 == list_len);
            end
        endcase
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected result", m_tdata, 0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (m_tdata[STATUS_W-1:0] != want.status)
                report("status", m_tdata[STATUS_W-1:0], want.status);
            if (m_tdata[ELEM_LO +: DATA_WIDTH] != want.element)
                report("element", m_tdata[ELEM_LO +: DATA_WIDTH], want.element);
            if (m_tdata[INDEX_LO +: IDX_W] != want.index)
                report("index", m_tdata[INDEX_LO +: IDX_W], want.index);
            if (m_tdata[COUNT_LO +: CNT_W] != want.cnt)
                report("count", m_tdata[COUNT_LO +: CNT_W], want.cnt);
            if (m_tlast !== want.is_last)
                report("tlast", m_tlast, want.is_last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                predict_list_op(op_t'(s_tuser), int'(s_tdata[POS_W-1:0]),
                                s_tdata[POS_W +: DATA_WIDTH]);
            outstanding = pending_results.size();
        end
    end

endmodule

[bench/positional_list_engine_test.sv]
`timescale 1ns / 100ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata = '0;   // position, data
    logic [OP_W-1:0]            s_tuser = '0;   // operation
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_tdata;        // status, element, index, count
    logic                       m_tlast;

    int                         mismatches;
    int                         outstanding;
    int                         quiet_cycles = 0;
    bit                         no_gaps = 0;
    logic [DATA_WIDTH-1:0]      value_pool [6];

    positional_list_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    positional_list_engine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // no progress on either channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off to back up the block
    initial
    begin
        int  stall;
        int  taken;
        bit  held;
        stall = 0;
        taken = 0;
        held  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                taken++;
                stall = no_gaps ? 0 : $urandom_range(0, 4);
                if (taken == 60 && !held)
                begin
                    stall = 80;
                    held  = 1;
                end
            end
            else if (!m_tready && stall > 0)
            begin
                stall--;
            end
            m_tready <= rst_n && stall == 0;
        end
    end

    task automatic send_request(input op_t op, input int pos,
                                input logic [DATA_WIDTH-1:0] word);
        int                     gap;
        logic [IN_TDATA_W-1:0]  packed_req;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        packed_req = '0;
        packed_req[POS_W-1:0] = POS_W'(pos);
        packed_req[POS_W +: DATA_WIDTH] = word;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packed_req;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic op_t pick_op(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       return roll < 70 ? OP_INSERT : roll < 80 ? OP_DEL_POS :
                            roll < 92 ? OP_DEL_VAL : OP_TRAVERSE;
            1:       return roll < 15 ? OP_INSERT : roll < 55 ? OP_DEL_POS :
                            roll < 90 ? OP_DEL_VAL : OP_TRAVERSE;
            default: return roll < 40 ? OP_INSERT : roll < 62 ? OP_DEL_POS :
                            roll < 85 ? OP_DEL_VAL : OP_TRAVERSE;
        endcase
    endfunction

    initial
    begin
        int mode;
        int pos;
        logic [DATA_WIDTH-1:0] word;

        foreach (value_pool[i])
            value_pool[i] = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, extremes, every operation
        send_request(OP_TRAVERSE, 0, '0);
        send_request(OP_DEL_POS, 0, '0);
        send_request(OP_DEL_VAL, 0, '1);
        send_request(OP_INSERT, 255, '1);
        send_request(OP_INSERT, 0, '0);
        send_request(OP_INSERT, 1, 32'hA5A5_A5A5);
        send_request(OP_TRAVERSE, 255, '1);
        send_request(OP_DEL_POS, 3, '0);
        send_request(OP_DEL_VAL, 0, 32'h1234_5678);
        send_request(OP_DEL_VAL, 0, 32'hA5A5_A5A5);
        // fill to capacity, then overflow
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(OP_INSERT, i % 3 == 0 ? 0 : 200, 32'h5A5A_0000 + i);
        send_request(OP_INSERT, 7, 32'hDEAD_BEEF);
        send_request(OP_TRAVERSE, 0, '0);
        wait_all_results();

        for (int phase = 0; phase < 9; phase++)
        begin
            mode    = phase % 3;
            no_gaps = $urandom_range(0, 3) == 0;
            for (int n = 0; n < 30; n++)
            begin
                pos  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
                                                    $urandom_range(0, DEPTH + 1);
                word = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 5)] : $urandom;
                send_request(pick_op(mode), pos, word);
            end
            if (phase == 4)
                wait_all_results();
        end
        no_gaps = 0;

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[positional_list_engine.f]
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
bench/positional_list_engine_checker.sv
bench/positional_list_engine_test.sv
